// ----- src/dla_pkg.sv -----
package dla_pkg;

	localparam int MAC_W      = 48;
	localparam int IP_W       = 32;
	localparam int TIME_W     = 32;
	localparam int EXP_W      = 16;
	localparam int HOST_W     = 8;
	localparam int SLOT_OUT_W = 3;
	localparam int LEASE_W    = 23;
	localparam int OP_W       = 2;
	localparam int VERDICT_W  = 2;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int MS_W       = 10;

	localparam logic [MS_W-1:0] MS_PER_SEC = 10'd1000;

	localparam logic [OP_W-1:0] OP_DISCOVER = 2'd0;
	localparam logic [OP_W-1:0] OP_REQUEST  = 2'd1;

	localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_OFFER = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_ACK   = 2'd2;

	localparam logic [1:0] REG_SERVER_ADDRESS = 2'd0;
	localparam logic [1:0] REG_BASE_HOST      = 2'd1;
	localparam logic [1:0] REG_LEASE_SECONDS  = 2'd2;

	localparam logic [IP_W-1:0]    SERVER_ADDRESS_RESET = 32'd0;
	localparam logic [HOST_W-1:0]  BASE_HOST_RESET      = 8'd16;
	localparam logic [LEASE_W-1:0] LEASE_SECONDS_RESET  = 23'd86400;

	// Outcome of comparing one lease slot against the current client.
	typedef struct packed {
		logic match;
		logic is_free;
		logic expired;
	} eval_res_t;

endpackage

// ----- src/dla_table.sv -----
module dla_table #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [dla_pkg::MAC_W-1:0]    rd_owner,
	output logic [dla_pkg::EXP_W-1:0]    rd_expiry,
	input  logic                         owner_we,
	input  logic                         expiry_we,
	input  logic [IDX_W-1:0]             wr_addr,
	input  logic [dla_pkg::MAC_W-1:0]    wr_owner,
	input  logic [dla_pkg::EXP_W-1:0]    wr_expiry
);

	logic [dla_pkg::MAC_W-1:0] owner_mem [DEPTH];
	logic [dla_pkg::EXP_W-1:0] expiry_mem [DEPTH];
	logic [DEPTH-1:0]          valid_q;
	logic [dla_pkg::MAC_W-1:0] owner_rd_q;
	logic [dla_pkg::EXP_W-1:0] expiry_rd_q;
	logic                      valid_rd_q;

	// An entry becomes valid when a request writes both owner and expiry.
	// Clearing an owner leaves the valid bit alone: an entry that was never
	// written already reads as a free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (expiry_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (owner_we) begin
			owner_mem[wr_addr] <= wr_owner;
		end
		if (expiry_we) begin
			expiry_mem[wr_addr] <= wr_expiry;
		end
		if (rd_en) begin
			owner_rd_q  <= owner_mem[rd_addr];
			expiry_rd_q <= expiry_mem[rd_addr];
			valid_rd_q  <= valid_q[rd_addr];
		end
	end

	assign rd_owner  = valid_rd_q ? owner_rd_q : '0;
	assign rd_expiry = valid_rd_q ? expiry_rd_q : '0;

endmodule

// ----- src/dla_eval.sv -----
module dla_eval (
	input  logic [dla_pkg::MAC_W-1:0]  owner,
	input  logic [dla_pkg::EXP_W-1:0]  expiry,
	input  logic [dla_pkg::MAC_W-1:0]  client_mac,
	input  logic [dla_pkg::TIME_W-1:0] now_ms,
	output dla_pkg::eval_res_t         res
);

	logic [dla_pkg::TIME_W-1:0] end_time;
	logic [dla_pkg::TIME_W-1:0] diff;

	// The coarse expiry covers the whole 65.536 s window of its upper bits.
	assign end_time = {expiry, 16'hffff};
	assign diff     = end_time - now_ms;

	assign res.match   = (owner == client_mac);
	assign res.is_free = (owner == '0);
	assign res.expired = diff[dla_pkg::TIME_W-1];

endmodule

// ----- src/dhcp_lease_allocator_top.sv -----
// Discover: the lease table is read one slot per cycle; the scan stops at the first slot
// that the client already owns, else it runs through the last slot.
// Request: check and slot read, compare and write, output; a failed check skips to output.
// Other types go straight to output. One item is in work at a time; s_axis_tready rises
// together with m_axis_tvalid, and a stalled output holds the result stage.
// Reset: arst_n clears the control state and marks every lease slot free with no clearing pass.
module dhcp_lease_allocator_top #(
	parameter int LEASE_SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// client_mac[47:0], requested_address[79:48], now_ms[111:80]
	input  logic [111:0]  s_axis_tdata,
	// op[1:0], requested_present[2]
	input  logic [2:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// offered_host[7:0], slot_index[10:8], zero fill[15:11]
	output logic [15:0]   m_axis_tdata,
	// verdict[1:0]
	output logic [1:0]    m_axis_tuser,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
	localparam int CNT_W = $clog2(LEASE_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEASE_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_SCAN     = 5'b00010,
		ST_REQ_CHK  = 5'b00100,
		ST_REQ_EVAL = 5'b01000,
		ST_EMIT     = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [dla_pkg::IP_W-1:0]    server_q;
	logic [dla_pkg::HOST_W-1:0]  base_q;
	logic [dla_pkg::LEASE_W-1:0] lease_q;

	logic [dla_pkg::MAC_W-1:0]   mac_q;
	logic                        present_q;
	logic [dla_pkg::IP_W-1:0]    req_q;
	logic [dla_pkg::TIME_W-1:0]  now_q;
	logic [dla_pkg::TIME_W-1:0]  prod_q;

	logic [CNT_W-1:0]            rd_cnt_q;
	logic                        dv_q;
	logic [IDX_W-1:0]            ev_idx_q;
	logic                        picked_q;
	logic [IDX_W-1:0]            pick_q;

	logic [dla_pkg::VERDICT_W-1:0] res_verdict_q, res_verdict_d;
	logic [IDX_W-1:0]              res_slot_q, res_slot_d;
	logic                          m_valid_q;
	logic [dla_pkg::VERDICT_W-1:0] m_verdict_q;
	logic [dla_pkg::HOST_W-1:0]    m_host_q;
	logic [dla_pkg::SLOT_OUT_W-1:0] m_slot_q;

	logic                        accept;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic                        owner_we;
	logic                        expiry_we;
	logic [IDX_W-1:0]            wr_addr;
	logic [dla_pkg::MAC_W-1:0]   wr_owner;
	logic [dla_pkg::EXP_W-1:0]   wr_expiry;
	logic [dla_pkg::MAC_W-1:0]   rd_owner;
	logic [dla_pkg::EXP_W-1:0]   rd_expiry;
	dla_pkg::eval_res_t          ev;
	logic                        res_load;
	logic                        pick_set;
	logic                        out_load;

	logic                        cfg_wr;
	logic [1:0]                  cfg_idx;
	logic [dla_pkg::LEASE_W+dla_pkg::MS_W-1:0] mul_full;
	logic [dla_pkg::TIME_W-1:0]  new_end;
	logic [dla_pkg::HOST_W-1:0]  req_slot;
	logic                        req_ok;
	logic [IDX_W+dla_pkg::HOST_W-1:0] host_sum;
	logic [IDX_W+2:0]            slot_ext;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_q <= dla_pkg::SERVER_ADDRESS_RESET;
			base_q   <= dla_pkg::BASE_HOST_RESET;
			lease_q  <= dla_pkg::LEASE_SECONDS_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				dla_pkg::REG_SERVER_ADDRESS: server_q <= pwdata;
				dla_pkg::REG_BASE_HOST:      base_q   <= pwdata[dla_pkg::HOST_W-1:0];
				dla_pkg::REG_LEASE_SECONDS:  lease_q  <= pwdata[dla_pkg::LEASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			dla_pkg::REG_SERVER_ADDRESS: prdata = server_q;
			dla_pkg::REG_BASE_HOST:      prdata = {24'd0, base_q};
			dla_pkg::REG_LEASE_SECONDS:  prdata = {9'd0, lease_q};
			default:                     prdata = '0;
		endcase
	end

	// Lease table and the shared slot compare unit.
	dla_table #(
		.DEPTH (LEASE_SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_owner  (rd_owner),
		.rd_expiry (rd_expiry),
		.owner_we  (owner_we),
		.expiry_we (expiry_we),
		.wr_addr   (wr_addr),
		.wr_owner  (wr_owner),
		.wr_expiry (wr_expiry)
	);

	dla_eval u_eval (
		.owner      (rd_owner),
		.expiry     (rd_expiry),
		.client_mac (mac_q),
		.now_ms     (now_q),
		.res        (ev)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign mul_full = lease_q * dla_pkg::MS_PER_SEC;
	assign new_end  = now_q + prod_q;
	assign req_slot = req_q[dla_pkg::HOST_W-1:0] - base_q;
	assign req_ok   = present_q && (req_q[31:8] == server_q[31:8]) &&
		(req_slot < dla_pkg::HOST_W'(LEASE_SLOTS));

	always_comb begin
		state_d       = state_q;
		rd_en         = 1'b0;
		rd_addr       = rd_cnt_q[IDX_W-1:0];
		owner_we      = 1'b0;
		expiry_we     = 1'b0;
		wr_addr       = ev_idx_q;
		wr_owner      = mac_q;
		wr_expiry     = new_end[31:16];
		res_load      = 1'b0;
		res_verdict_d = dla_pkg::VERDICT_DROP;
		res_slot_d    = ev_idx_q;
		pick_set      = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser[1:0] == dla_pkg::OP_DISCOVER) begin
						state_d = ST_SCAN;
					end else if (s_axis_tuser[1:0] == dla_pkg::OP_REQUEST) begin
						state_d = ST_REQ_CHK;
					end else begin
						res_load = 1'b1;
						state_d  = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				// Reads run one slot ahead of the compare.
				rd_en = (rd_cnt_q < CNT_W'(LEASE_SLOTS));
				if (dv_q) begin
					if (ev.match) begin
						res_load      = 1'b1;
						res_verdict_d = dla_pkg::VERDICT_OFFER;
						state_d       = ST_EMIT;
					end else begin
						if (!picked_q && (ev.is_free || ev.expired)) begin
							pick_set = 1'b1;
							if (ev.expired) begin
								owner_we = 1'b1;
								wr_owner = '0;
							end
						end
						if (ev_idx_q == LAST_IDX) begin
							res_load = 1'b1;
							state_d  = ST_EMIT;
							if (picked_q) begin
								res_verdict_d = dla_pkg::VERDICT_OFFER;
								res_slot_d    = pick_q;
							end else if (pick_set) begin
								res_verdict_d = dla_pkg::VERDICT_OFFER;
							end
						end
					end
				end
			end
			ST_REQ_CHK: begin
				if (req_ok) begin
					rd_en   = 1'b1;
					rd_addr = req_slot[IDX_W-1:0];
					state_d = ST_REQ_EVAL;
				end else begin
					res_load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_REQ_EVAL: begin
				res_load = 1'b1;
				state_d  = ST_EMIT;
				if (ev.match || ev.is_free) begin
					owner_we      = 1'b1;
					expiry_we     = 1'b1;
					res_verdict_d = dla_pkg::VERDICT_ACK;
				end
			end
			ST_EMIT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			dv_q     <= 1'b0;
			picked_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_cnt_q <= '0;
				dv_q     <= 1'b0;
				picked_q <= 1'b0;
			end else begin
				dv_q <= rd_en;
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (pick_set) begin
					picked_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mac_q     <= s_axis_tdata[47:0];
			req_q     <= s_axis_tdata[79:48];
			now_q     <= s_axis_tdata[111:80];
			present_q <= s_axis_tuser[2];
		end
		if (rd_en) begin
			ev_idx_q <= rd_addr;
		end
		if (pick_set) begin
			pick_q <= ev_idx_q;
		end
		if (res_load) begin
			res_verdict_q <= res_verdict_d;
			res_slot_q    <= res_slot_d;
		end
		prod_q <= mul_full[dla_pkg::TIME_W-1:0];
	end

	// Output register: host and slot read as zero on a drop.
	assign host_sum = {{IDX_W{1'b0}}, base_q} + {{dla_pkg::HOST_W{1'b0}}, res_slot_q};
	assign slot_ext = {3'd0, res_slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_verdict_q <= res_verdict_q;
			if (res_verdict_q == dla_pkg::VERDICT_DROP) begin
				m_host_q <= '0;
				m_slot_q <= '0;
			end else begin
				m_host_q <= host_sum[dla_pkg::HOST_W-1:0];
				m_slot_q <= slot_ext[dla_pkg::SLOT_OUT_W-1:0];
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_slot_q, m_host_q};
	assign m_axis_tuser  = m_verdict_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input accepted again while an item was in work");

	a_expiry_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		expiry_we |-> (state_q == ST_REQ_EVAL) && owner_we)
		else $error("expiry written outside a request commit");

	a_owner_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		owner_we |-> (state_q == ST_SCAN) || (state_q == ST_REQ_EVAL))
		else $error("lease owner written outside scan or request commit");

	a_drop_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == dla_pkg::VERDICT_DROP) |-> (m_axis_tdata == '0))
		else $error("dropped item carries a host or slot");

	a_emit_follows_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !$past(state_q == ST_EMIT) |-> $past(res_load))
		else $error("result stage entered without a loaded result");

endmodule

// ----- test/tb_dhcp_lease_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_dhcp_lease_allocator_top;

	localparam int LEASE_SLOTS = 8;
	localparam int IDX_W = $clog2(LEASE_SLOTS);
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [dla_pkg::OP_W-1:0] OP_OTHER    = 2'd2;
	localparam logic [dla_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

	typedef struct packed {
		logic [dla_pkg::VERDICT_W-1:0]  verdict;
		logic [dla_pkg::HOST_W-1:0]     host;
		logic [dla_pkg::SLOT_OUT_W-1:0] slot;
	} lease_reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// client_mac[47:0], requested_address[79:48], now_ms[111:80]
	logic [111:0] s_axis_tdata = '0;
	// op[1:0], requested_present[2]
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// offered_host[7:0], slot_index[10:8], zero fill[15:11]
	logic [15:0]  m_axis_tdata;
	// verdict[1:0]
	logic [1:0]   m_axis_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	dhcp_lease_allocator_top #(.LEASE_SLOTS(LEASE_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow lease table and registers, advanced on every accepted item and write.
	logic [dla_pkg::MAC_W-1:0]   lease_owner [LEASE_SLOTS];
	logic [dla_pkg::EXP_W-1:0]   lease_expiry [LEASE_SLOTS];
	logic [dla_pkg::IP_W-1:0]    cfg_server = dla_pkg::SERVER_ADDRESS_RESET;
	logic [dla_pkg::HOST_W-1:0]  cfg_base = dla_pkg::BASE_HOST_RESET;
	logic [dla_pkg::LEASE_W-1:0] cfg_lease = dla_pkg::LEASE_SECONDS_RESET;

	lease_reply_t pending_replies [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_req = 0;
	int stall_taken = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	logic [dla_pkg::TIME_W-1:0] clock_ms = '0;
	logic [dla_pkg::MAC_W-1:0]  client_pool [10];

	initial begin
		for (int i = 0; i < LEASE_SLOTS; i++) begin
			lease_owner[i] = '0;
			lease_expiry[i] = '0;
		end
	end

	function automatic lease_reply_t predict_lease(input logic [dla_pkg::OP_W-1:0] op,
			input logic [dla_pkg::MAC_W-1:0] mac, input logic present,
			input logic [dla_pkg::IP_W-1:0] addr, input logic [dla_pkg::TIME_W-1:0] now);
		lease_reply_t r;
		int pick;
		logic hit;
		logic [31:0] margin;
		logic [31:0] lease_ms;
		logic [31:0] lease_end;
		logic [dla_pkg::HOST_W-1:0] slot8;
		logic [IDX_W-1:0] sidx;
		int chosen;
		r = '0;
		r.verdict = dla_pkg::VERDICT_DROP;
		chosen = 0;
		if (op == dla_pkg::OP_DISCOVER) begin
			pick = LEASE_SLOTS;
			hit = 1'b0;
			for (int i = 0; i < LEASE_SLOTS; i++) begin
				if (!hit) begin
					if (lease_owner[i] == mac) begin
						pick = i;
						hit = 1'b1;
					end else if (pick == LEASE_SLOTS) begin
						if (lease_owner[i] == '0)
							pick = i;
						// A slot is gone once its coarse end time lies behind now.
						margin = {lease_expiry[i], 16'hffff} - now;
						if (margin[31]) begin
							lease_owner[i] = '0;
							pick = i;
						end
					end
				end
			end
			if (pick < LEASE_SLOTS) begin
				r.verdict = dla_pkg::VERDICT_OFFER;
				chosen = pick;
			end
		end else if (op == dla_pkg::OP_REQUEST) begin
			if (present && addr[31:8] == cfg_server[31:8]) begin
				slot8 = addr[7:0] - cfg_base;
				sidx = slot8[IDX_W-1:0];
				if (slot8 < LEASE_SLOTS &&
						(lease_owner[sidx] == mac || lease_owner[sidx] == '0)) begin
					lease_owner[sidx] = mac;
					lease_ms = {9'b0, cfg_lease} * 32'd1000;
					lease_end = now + lease_ms;
					lease_expiry[sidx] = lease_end[31:16];
					r.verdict = dla_pkg::VERDICT_ACK;
					chosen = int'(slot8);
				end
			end
		end
		if (r.verdict != dla_pkg::VERDICT_DROP) begin
			r.host = cfg_base + chosen[dla_pkg::HOST_W-1:0];
			r.slot = chosen[dla_pkg::SLOT_OUT_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		lease_reply_t got;
		lease_reply_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.verdict = m_axis_tuser;
			got.host = m_axis_tdata[7:0];
			got.slot = m_axis_tdata[10:8];
			if (pending_replies.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected reply: verdict %0d host %0d slot %0d",
						got.verdict, got.host, got.slot);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (got.verdict != want.verdict || got.host != want.host ||
						got.slot != want.slot) begin
					if (mismatches < 10)
						$display("reply mismatch: verdict %0d/%0d host %0d/%0d slot %0d/%0d %s",
							want.verdict, got.verdict, want.host, got.host,
							want.slot, got.slot, "(expected/actual)");
					mismatches++;
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready)
			pending_replies.push_back(predict_lease(s_axis_tuser[1:0], s_axis_tdata[47:0],
				s_axis_tuser[2], s_axis_tdata[79:48], s_axis_tdata[111:80]));
		if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				dla_pkg::REG_SERVER_ADDRESS: cfg_server <= pwdata;
				dla_pkg::REG_BASE_HOST:      cfg_base <= pwdata[dla_pkg::HOST_W-1:0];
				dla_pkg::REG_LEASE_SECONDS:  cfg_lease <= pwdata[dla_pkg::LEASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Reply side: random stalls, plus a long hold whenever the test asks for one.
	always @(posedge clk) begin
		if (stall_taken != stall_req) begin
			stall_taken <= stall_req;
			stall_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_event(input logic [dla_pkg::OP_W-1:0] op,
			input logic [dla_pkg::MAC_W-1:0] mac, input logic present,
			input logic [dla_pkg::IP_W-1:0] addr, input logic [dla_pkg::TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {now, addr, mac};
		s_axis_tuser <= {present, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Wait until every reply is back and the block has had time to go quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_default_config();
		logic [dla_pkg::MAC_W-1:0] mac_a;
		logic [dla_pkg::MAC_W-1:0] mac_b;
		mac_a = 48'h0200_0000_00a1;
		mac_b = 48'h0200_0000_00b2;
		send_event(dla_pkg::OP_DISCOVER, mac_a, 1'b0, 32'h0, 32'd1000);
		send_event(dla_pkg::OP_REQUEST, mac_a, 1'b1, 32'h0000_0010, 32'd1000);
		send_event(dla_pkg::OP_DISCOVER, mac_a, 1'b0, 32'hffff_ffff, 32'd2000);
		send_event(dla_pkg::OP_DISCOVER, mac_b, 1'b0, 32'h0, 32'd2000);
		// Slot held by another client, then missing address, wrong prefix, out of range.
		send_event(dla_pkg::OP_REQUEST, mac_b, 1'b1, 32'h0000_0010, 32'd3000);
		send_event(dla_pkg::OP_REQUEST, mac_b, 1'b0, 32'h0000_0011, 32'd3000);
		send_event(dla_pkg::OP_REQUEST, mac_b, 1'b1, 32'h0100_0011, 32'd3000);
		send_event(dla_pkg::OP_REQUEST, mac_b, 1'b1, 32'h0000_0018, 32'd3000);
		send_event(dla_pkg::OP_REQUEST, mac_b, 1'b1, 32'h0000_000f, 32'd3000);
		send_event(OP_OTHER, mac_a, 1'b1, 32'h0000_0010, 32'd4000);
		send_event(OP_RESERVED, '1, 1'b1, '1, '1);
		// A zero client MAC matches any free slot as its own.
		send_event(dla_pkg::OP_DISCOVER, '0, 1'b0, 32'h0, 32'd5000);
		send_event(dla_pkg::OP_REQUEST, '1, 1'b1, 32'h0000_0017, 32'hffff_ffff);
		send_event(dla_pkg::OP_REQUEST, '0, 1'b1, 32'h0000_0011, 32'd6000);
		settle();
	endtask

	task automatic test_full_table();
		logic [dla_pkg::TIME_W-1:0] t0;
		write_reg(dla_pkg::REG_SERVER_ADDRESS, 32'hc0a8_0101);
		write_reg(dla_pkg::REG_BASE_HOST, 32'd250);
		write_reg(dla_pkg::REG_LEASE_SECONDS, 32'd1);
		t0 = 32'h0010_0000;
		// Base near the top of the octet, so the slot addresses wrap past 255.
		for (int i = 0; i < LEASE_SLOTS; i++)
			send_event(dla_pkg::OP_REQUEST, 48'h0a00_0000_0000 + i, 1'b1,
				{24'hc0a801, 8'(250 + i)}, t0);
		send_event(dla_pkg::OP_DISCOVER, 48'h0b00_0000_0001, 1'b0, 32'h0, t0);
		// Slot zero has run out: it is cleared even though slot three is this client's.
		send_event(dla_pkg::OP_DISCOVER, 48'h0a00_0000_0003, 1'b0, 32'h0,
			t0 + 32'h0003_0000);
		send_event(dla_pkg::OP_DISCOVER, 48'h0b00_0000_0001, 1'b0, 32'h0,
			t0 + 32'h0003_0000);
		settle();
		write_reg(dla_pkg::REG_LEASE_SECONDS, 32'd4294967);
		write_reg(dla_pkg::REG_BASE_HOST, 32'd0);
		write_reg(dla_pkg::REG_SERVER_ADDRESS, 32'hffff_ffff);
		send_event(dla_pkg::OP_REQUEST, 48'h0c00_0000_0001, 1'b1, 32'hffff_ff00,
			32'hfff0_0000);
		send_event(dla_pkg::OP_REQUEST, 48'h0c00_0000_0002, 1'b1, 32'hffff_ff07,
			32'h1234_5678);
		settle();
		write_reg(dla_pkg::REG_LEASE_SECONDS, 32'd0);
		send_event(dla_pkg::OP_REQUEST, 48'h0c00_0000_0003, 1'b1, 32'hffff_ff01,
			32'h8000_0000);
		settle();
	endtask

	task automatic test_random_traffic(input int count, input int send_pct,
			input int recv_pct, input logic [31:0] server, input logic [31:0] base,
			input logic [31:0] lease);
		logic [dla_pkg::OP_W-1:0] op;
		logic [dla_pkg::MAC_W-1:0] mac;
		logic [dla_pkg::IP_W-1:0] addr;
		logic present;
		int pick;
		write_reg(dla_pkg::REG_SERVER_ADDRESS, server);
		write_reg(dla_pkg::REG_BASE_HOST, base);
		write_reg(dla_pkg::REG_LEASE_SECONDS, lease);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		for (int i = 0; i < 10; i++)
			client_pool[i] = 48'({$urandom, $urandom});
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = dla_pkg::OP_DISCOVER;
			else if (pick < 90)
				op = dla_pkg::OP_REQUEST;
			else
				op = dla_pkg::OP_W'($urandom_range(OP_OTHER, OP_RESERVED));
			if ($urandom_range(9) == 0)
				mac = 48'({$urandom, $urandom});
			else
				mac = client_pool[$urandom_range(9)];
			present = ($urandom_range(9) != 0);
			if ($urandom_range(99) < 85)
				addr = {server[31:8], 8'(base + $urandom_range(0, 9))};
			else
				addr = $urandom;
			if ($urandom_range(9) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 50000);
			send_event(op, mac, present, addr, clock_ms);
		end
		settle();
	endtask

	// The reply side holds off while items keep coming, so the block backs up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		stall_req <= stall_req + 1;
		for (int n = 0; n < 12; n++) begin
			clock_ms = clock_ms + $urandom_range(0, 20000);
			send_event((n % 2 == 0) ? dla_pkg::OP_DISCOVER : dla_pkg::OP_REQUEST,
				client_pool[n % 10], 1'b1,
				{cfg_server[31:8], 8'(cfg_base + n % 8)}, clock_ms);
		end
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_config();
		test_full_table();
		test_random_traffic(150, 25, 81, 32'h0a00_0001, 32'd0, 32'd30);
		test_random_traffic(150, 81, 25, $urandom, 32'd255, 32'd5);
		test_random_traffic(150, 0, 0, 32'hc0a8_0101, 32'd100, 32'd4294967);
		test_backpressure();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
